// ===== hdl/rkx_pkg.sv =====
// Shared types and constants for the Rabbit keystream XOR block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rkx_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned KeyW   = 64;
    localparam int unsigned IvW    = 64;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CmdW   = 2;
    localparam int unsigned StepW  = 4;
    localparam int unsigned LastStep = 9;

    localparam logic [CmdW-1:0] CMD_KEY  = 2'd0;
    localparam logic [CmdW-1:0] CMD_IV   = 2'd1;
    localparam logic [CmdW-1:0] CMD_BYTE = 2'd2;

    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef logic [WordW-1:0] word_t;

    typedef struct packed {
        logic             capture;
        logic             load_key;
        logic             load_iv;
        logic             rnd_en;
        logic [StepW-1:0] step;
        logic             mix;
        logic             emit;
    } rkx_cmd_t;

    typedef struct packed {
        logic pos_zero;
        logic out_free;
    } rkx_status_t;

    function automatic word_t rc_a(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0, 3'd3, 3'd6: r = 32'h4D34D34D;
            3'd1, 3'd4, 3'd7: r = 32'hD34D34D3;
            default:          r = 32'h34D34D34;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rabbit_keystream_xor_top.sv =====
// Top level of the Rabbit keystream XOR block: controller plus datapath.
// Depends on rkx_pkg, rkx_ctrl, rkx_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Rabbit stream cipher (RFC 4503) with byte-wise XOR. s_tuser selects the
// transfer kind (key setup, IV setup, byte); key words must be written on
// the cfg port while idle; the block does not enforce this. Rounds run on
// a single shared 32x32 squarer (one counter word and one g value per
// cycle, then the state update). Key setup runs rounds and the counter
// mix, IV setup rounds only; a byte runs a round first when a new 16-byte
// keystream block is due. One transfer is in flight at a time; the output
// register lets the next transfer enter while a byte waits on m_tready.
module rabbit_keystream_xor_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // iv[63:0], data_in[71:64]
    input  wire logic [2:0]  s_tuser,   // command[1:0], fresh[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // data_out[7:0]
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [63:0] cfg_wdata
);
    import rkx_pkg::*;

    rkx_cmd_t    cmd;
    rkx_status_t status;

    rkx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser[1:0]),
        .in_fresh (s_tuser[2]),
        .status   (status),
        .cmd      (cmd)
    );

    rkx_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_iv     (s_tdata[63:0]),
        .in_data   (s_tdata[71:64]),
        .in_fresh  (s_tuser[2]),
        .out_data  (m_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule
`default_nettype wire

// ===== hdl/rkx_datapath.sv =====
// Datapath: key registers, cipher state, shared round unit, output register.
// Depends on rkx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rkx_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire rkx_pkg::rkx_cmd_t            cmd,
    output rkx_pkg::rkx_status_t              status,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_addr,
    input  wire logic [rkx_pkg::KeyW-1:0]     cfg_wdata,
    input  wire logic [rkx_pkg::IvW-1:0]      in_iv,
    input  wire logic [rkx_pkg::ByteW-1:0]    in_data,
    input  wire logic                         in_fresh,
    output logic [rkx_pkg::ByteW-1:0]         out_data,
    output logic                              out_valid,
    input  wire logic                         out_ready
);
    import rkx_pkg::*;

    logic [KeyW-1:0]  key_low_reg, key_high_reg;
    logic [IvW-1:0]   iv_reg;
    logic [ByteW-1:0] data_reg;
    logic             fresh_reg;
    word_t            x_reg [8];
    word_t            c_reg [8];
    logic             carry_reg;
    word_t            sx_reg [8];
    word_t            sc_reg [8];
    logic             scarry_reg;
    word_t            g_reg [8];
    word_t            sum_reg;
    logic [3:0]       pos_reg;
    logic             iv_applied_reg;
    logic [ByteW-1:0] out_reg;
    logic             valid_reg;

    logic [15:0]      k [8];
    word_t            kx [8];
    word_t            kc [8];
    word_t            ivw [8];
    word_t            xn [8];
    logic [WordW:0]   cnew;
    logic [2*WordW-1:0] prod;
    logic [127:0]     ks;
    logic [3:0]       idx;

    function automatic word_t r16(input word_t v);
        return {v[15:0], v[31:16]};
    endfunction
    function automatic word_t r8(input word_t v);
        return {v[23:0], v[31:24]};
    endfunction

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            k[i]   = key_low_reg[16*i +: 16];
            k[i+4] = key_high_reg[16*i +: 16];
        end
        for (int i = 0; i < 8; i++) begin
            if ((i % 2) == 0) begin
                kx[i] = {k[(i+1)%8], k[i]};
                kc[i] = {k[(i+4)%8], k[(i+5)%8]};
            end else begin
                kx[i] = {k[(i+5)%8], k[(i+4)%8]};
                kc[i] = {k[i], k[(i+1)%8]};
            end
        end
        ivw[0] = iv_reg[31:0];
        ivw[1] = {iv_reg[63:48], iv_reg[31:16]};
        ivw[2] = iv_reg[63:32];
        ivw[3] = {iv_reg[47:32], iv_reg[15:0]};
        for (int i = 4; i < 8; i++) ivw[i] = ivw[i-4];
    end

    assign cnew = {1'b0, c_reg[cmd.step[2:0]]} + {1'b0, rc_a(cmd.step[2:0])}
                + {{WordW{1'b0}}, carry_reg};
    assign prod = {{WordW{1'b0}}, sum_reg} * {{WordW{1'b0}}, sum_reg};

    always_comb begin
        xn[0] = g_reg[0] + r16(g_reg[7]) + r16(g_reg[6]);
        xn[1] = g_reg[1] + r8(g_reg[0])  + g_reg[7];
        xn[2] = g_reg[2] + r16(g_reg[1]) + r16(g_reg[0]);
        xn[3] = g_reg[3] + r8(g_reg[2])  + g_reg[1];
        xn[4] = g_reg[4] + r16(g_reg[3]) + r16(g_reg[2]);
        xn[5] = g_reg[5] + r8(g_reg[4])  + g_reg[3];
        xn[6] = g_reg[6] + r16(g_reg[5]) + r16(g_reg[4]);
        xn[7] = g_reg[7] + r8(g_reg[6])  + g_reg[5];
    end

    assign ks = {
        (x_reg[6][31:16] ^ x_reg[1][15:0]),  (x_reg[6][15:0] ^ x_reg[3][31:16]),
        (x_reg[4][31:16] ^ x_reg[7][15:0]),  (x_reg[4][15:0] ^ x_reg[1][31:16]),
        (x_reg[2][31:16] ^ x_reg[5][15:0]),  (x_reg[2][15:0] ^ x_reg[7][31:16]),
        (x_reg[0][31:16] ^ x_reg[3][15:0]),  (x_reg[0][15:0] ^ x_reg[5][31:16])
    };
    assign idx = fresh_reg ? 4'd0 : pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            carry_reg      <= 1'b0;
            scarry_reg     <= 1'b0;
            pos_reg        <= '0;
            iv_applied_reg <= 1'b0;
            valid_reg      <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                x_reg[i]  <= '0;
                c_reg[i]  <= '0;
                sx_reg[i] <= '0;
                sc_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_KEY_LOW) key_low_reg <= cfg_wdata;
                else                         key_high_reg <= cfg_wdata;
            end
            if (cmd.load_key) begin
                carry_reg <= 1'b0;
                pos_reg   <= '0;
                for (int i = 0; i < 8; i++) begin
                    x_reg[i] <= kx[i];
                    c_reg[i] <= kc[i];
                end
            end
            if (cmd.load_iv) begin
                pos_reg        <= '0;
                iv_applied_reg <= 1'b1;
                if (iv_applied_reg) carry_reg <= scarry_reg;
                for (int i = 0; i < 8; i++) begin
                    if (iv_applied_reg) begin
                        x_reg[i] <= sx_reg[i];
                        c_reg[i] <= sc_reg[i] ^ ivw[i];
                    end else begin
                        c_reg[i] <= c_reg[i] ^ ivw[i];
                    end
                end
            end
            if (cmd.rnd_en) begin
                if (cmd.step < 4'd8) begin
                    c_reg[cmd.step[2:0]] <= cnew[WordW-1:0];
                    carry_reg            <= cnew[WordW];
                end
                if (cmd.step == 4'(LastStep)) begin
                    for (int i = 0; i < 8; i++) x_reg[i] <= xn[i];
                end
            end
            if (cmd.mix) begin
                scarry_reg <= carry_reg;
                for (int i = 0; i < 8; i++) begin
                    c_reg[i]  <= c_reg[i] ^ x_reg[(i+4)%8];
                    sc_reg[i] <= c_reg[i] ^ x_reg[(i+4)%8];
                    sx_reg[i] <= x_reg[i];
                end
            end
            if (cmd.emit) begin
                pos_reg   <= idx + 4'd1;
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            iv_reg    <= in_iv;
            data_reg  <= in_data;
            fresh_reg <= in_fresh;
        end
        if (cmd.rnd_en) begin
            if (cmd.step < 4'd8) sum_reg <= x_reg[cmd.step[2:0]] + cnew[WordW-1:0];
            if (cmd.step >= 4'd1 && cmd.step <= 4'd8)
                g_reg[3'(cmd.step - 4'd1)] <= prod[WordW-1:0] ^ prod[2*WordW-1:WordW];
        end
        if (cmd.emit) out_reg <= data_reg ^ ks[{idx, 3'b000} +: 8];
    end

    assign status.pos_zero = (pos_reg == 4'd0);
    assign status.out_free = !valid_reg || out_ready;
    assign out_data  = out_reg;
    assign out_valid = valid_reg;

endmodule
`default_nettype wire

// ===== hdl/rkx_ctrl.sv =====
// Controller: sequences setup, rounds, mixing and byte output.
// Depends on rkx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rkx_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [rkx_pkg::CmdW-1:0]    in_cmd,
    input  wire logic                        in_fresh,
    input  wire rkx_pkg::rkx_status_t        status,
    output rkx_pkg::rkx_cmd_t                cmd
);
    import rkx_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KEY  = 3'd1;
    localparam logic [2:0] S_IV   = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_MIX  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;
    logic [1:0]       rnd_reg, rnd_next;
    logic [CmdW-1:0]  op_reg, op_next;
    logic             acc;

    assign in_ready = (state_reg == S_IDLE);
    assign acc      = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        rnd_next   = rnd_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.capture = acc;
        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    op_next   = in_cmd;
                    step_next = '0;
                    case (in_cmd)
                        CMD_KEY: begin
                            state_next = S_KEY;
                            rnd_next   = 2'd3;
                        end
                        CMD_IV: begin
                            state_next = S_IV;
                            rnd_next   = 2'd3;
                        end
                        CMD_BYTE: begin
                            rnd_next   = 2'd0;
                            state_next = (in_fresh || status.pos_zero) ? S_RND : S_OUT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_KEY: begin
                cmd.load_key = 1'b1;
                state_next   = S_RND;
            end
            S_IV: begin
                cmd.load_iv = 1'b1;
                state_next  = S_RND;
            end
            S_RND: begin
                cmd.rnd_en = 1'b1;
                if (step_reg == 4'(LastStep)) begin
                    step_next = '0;
                    if (rnd_reg == 2'd0) begin
                        case (op_reg)
                            CMD_KEY:  state_next = S_MIX;
                            CMD_BYTE: state_next = S_OUT;
                            default:  state_next = S_IDLE;
                        endcase
                    end else begin
                        rnd_next = rnd_reg - 2'd1;
                    end
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_MIX: begin
                cmd.mix    = 1'b1;
                state_next = S_IDLE;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            rnd_reg   <= '0;
            op_reg    <= CMD_KEY;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            rnd_reg   <= rnd_next;
            op_reg    <= op_next;
        end
    end

endmodule
`default_nettype wire

// ===== verif/rabbit_keystream_xor_top_test.sv =====
// Testbench for rabbit_keystream_xor_top: key/IV setup and byte XOR transfers
// checked against an in-bench Rabbit cipher predictor. Depends on rkx_pkg.
`timescale 1ns / 1ps
module rabbit_keystream_xor_top_test;
    import rkx_pkg::*;

    localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] iv;
        logic [7:0]  din;
        logic        fresh;
    } xfer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [63:0] cfg_wdata = '0;

    rabbit_keystream_xor_top i_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [63:0] key_lo, key_hi;
    word_t       x_w[8], c_w[8], sx_w[8], sc_w[8];
    logic        carry, s_carry, iv_done;
    logic [7:0]  ks[16];
    logic [3:0]  pos;

    xfer_t       pending[$];
    logic [7:0]  exp_bytes[$];
    int          errors = 0;
    longint      cycles = 0;
    int          gap_in = 0, gap_out = 0;

    function automatic word_t rotl(word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic word_t gfn(word_t u, word_t v);
        logic [63:0] s;
        word_t t;
        t = u + v;
        s = {32'd0, t} * {32'd0, t};
        return s[31:0] ^ s[63:32];
    endfunction

    function automatic word_t ca(int j);
        case (j % 3)
            0: return 32'h4D34D34D;
            1: return 32'hD34D34D3;
            default: return 32'h34D34D34;
        endcase
    endfunction

    task automatic cipher_round();
        word_t g[8];
        logic [32:0] t;
        for (int j = 0; j < 8; j++) begin
            t = {1'b0, c_w[j]} + {1'b0, ca(j)} + {32'd0, carry};
            carry = t[32];
            c_w[j] = t[31:0];
        end
        for (int j = 0; j < 8; j++) g[j] = gfn(x_w[j], c_w[j]);
        x_w[0] = g[0] + rotl(g[7], 16) + rotl(g[6], 16);
        x_w[1] = g[1] + rotl(g[0], 8) + g[7];
        x_w[2] = g[2] + rotl(g[1], 16) + rotl(g[0], 16);
        x_w[3] = g[3] + rotl(g[2], 8) + g[1];
        x_w[4] = g[4] + rotl(g[3], 16) + rotl(g[2], 16);
        x_w[5] = g[5] + rotl(g[4], 8) + g[3];
        x_w[6] = g[6] + rotl(g[5], 16) + rotl(g[4], 16);
        x_w[7] = g[7] + rotl(g[6], 8) + g[5];
    endtask

    task automatic predict(xfer_t it);
        logic [15:0] k[8];
        word_t lo, hi, m1, m3, p[8];
        case (it.cmd)
            CMD_KEY: begin
                for (int i = 0; i < 4; i++) begin
                    k[i] = key_lo[16*i +: 16];
                    k[i+4] = key_hi[16*i +: 16];
                end
                carry = 1'b0;
                for (int i = 0; i < 8; i++) begin
                    if (i % 2 == 0) begin
                        x_w[i] = {k[(i+1)%8], k[i]};
                        c_w[i] = {k[(i+4)%8], k[(i+5)%8]};
                    end else begin
                        x_w[i] = {k[(i+5)%8], k[(i+4)%8]};
                        c_w[i] = {k[i], k[(i+1)%8]};
                    end
                end
                repeat (4) cipher_round();
                for (int i = 0; i < 8; i++) c_w[i] ^= x_w[(i+4)%8];
                sx_w = x_w;
                sc_w = c_w;
                s_carry = carry;
                pos = 4'd0;
            end
            CMD_IV: begin
                lo = it.iv[31:0];
                hi = it.iv[63:32];
                m1 = {hi[31:16], lo[31:16]};
                m3 = {hi[15:0], lo[15:0]};
                if (iv_done) begin
                    x_w = sx_w;
                    c_w = sc_w;
                    carry = s_carry;
                end
                iv_done = 1'b1;
                for (int i = 0; i < 8; i += 4) begin
                    c_w[i] ^= lo;
                    c_w[i+1] ^= m1;
                    c_w[i+2] ^= hi;
                    c_w[i+3] ^= m3;
                end
                repeat (4) cipher_round();
                pos = 4'd0;
            end
            CMD_BYTE: begin
                if (it.fresh) pos = 4'd0;
                if (pos == 4'd0) begin
                    cipher_round();
                    p[0] = x_w[0] ^ (x_w[5] >> 16);
                    p[1] = (x_w[0] >> 16) ^ x_w[3];
                    p[2] = x_w[2] ^ (x_w[7] >> 16);
                    p[3] = (x_w[2] >> 16) ^ x_w[5];
                    p[4] = x_w[4] ^ (x_w[1] >> 16);
                    p[5] = (x_w[4] >> 16) ^ x_w[7];
                    p[6] = x_w[6] ^ (x_w[3] >> 16);
                    p[7] = (x_w[6] >> 16) ^ x_w[1];
                    for (int i = 0; i < 8; i++) begin
                        ks[2*i] = p[i][7:0];
                        ks[2*i+1] = p[i][15:8];
                    end
                end
                exp_bytes.push_back(it.din ^ ks[pos]);
                pos = pos + 4'd1;
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict(pending.pop_front());
                gap_in <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
                s_tvalid <= 1'b0;
            end else if (!s_tvalid && pending.size() > 0) begin
                if (gap_in > 0) begin
                    gap_in <= gap_in - 1;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending[0].din, pending[0].iv};
                    s_tuser <= {pending[0].fresh, pending[0].cmd};
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (exp_bytes.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: unexpected byte, expected none, actual %02h",
                             $time, m_tdata);
                end else if (m_tdata !== exp_bytes[0]) begin
                    errors <= errors + 1;
                    $display("%0t: data_out mismatch, expected %02h, actual %02h",
                             $time, exp_bytes[0], m_tdata);
                    void'(exp_bytes.pop_front());
                end else begin
                    void'(exp_bytes.pop_front());
                end
                gap_out <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
                m_tready <= 1'b0;
            end else if (gap_out > 0) begin
                gap_out <= gap_out - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > 400000) begin
            $display("rabbit_keystream_xor_top verification failed");
            $finish;
        end
    end

    function automatic xfer_t mk(logic [1:0] c, logic [63:0] v, logic [7:0] d,
                                 logic f);
        xfer_t t;
        t.cmd = c;
        t.iv = v;
        t.din = d;
        t.fresh = f;
        return t;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic drain();
        while (pending.size() > 0 || s_tvalid || exp_bytes.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_key(logic [63:0] lo, logic [63:0] hi);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= REG_KEY_LOW;
        cfg_wdata <= lo;
        key_lo = lo;
        @(posedge aclk);
        cfg_addr <= REG_KEY_HIGH;
        cfg_wdata <= hi;
        key_hi = hi;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_session(int nbytes);
        logic [1:0] c;
        pending.push_back(mk(CMD_IV, rnd64(), 8'($urandom), 1'($urandom)));
        for (int i = 0; i < nbytes; i++) begin
            c = CMD_BYTE;
            if ($urandom_range(0, 60) == 0) c = CMD_UNUSED;
            if ($urandom_range(0, 80) == 0) c = CMD_IV;
            if ($urandom_range(0, 150) == 0) c = CMD_KEY;
            pending.push_back(mk(c, rnd64(), 8'($urandom), $urandom_range(0, 19) == 0));
        end
    endtask

    initial begin
        key_lo = '0; key_hi = '0;
        for (int i = 0; i < 8; i++) begin
            x_w[i] = '0; c_w[i] = '0; sx_w[i] = '0; sc_w[i] = '0;
        end
        for (int i = 0; i < 16; i++) ks[i] = '0;
        carry = 1'b0; s_carry = 1'b0; iv_done = 1'b0; pos = 4'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // bytes on reset state, an unused command, then extremes, wrap, fresh
        for (int i = 0; i < 3; i++) pending.push_back(mk(CMD_BYTE, '0, 8'h00, 1'b0));
        pending.push_back(mk(CMD_UNUSED, '1, 8'hFF, 1'b1));
        drain();
        write_key('1, '1);
        pending.push_back(mk(CMD_KEY, '0, 8'h00, 1'b0));
        for (int i = 0; i < 17; i++)
            pending.push_back(mk(CMD_BYTE, '1, (i % 2 != 0) ? 8'hFF : 8'h00, i == 5));
        pending.push_back(mk(CMD_IV, '0, 8'h00, 1'b0));
        pending.push_back(mk(CMD_BYTE, '0, 8'hA5, 1'b0));
        pending.push_back(mk(CMD_IV, '1, 8'h00, 1'b0));
        pending.push_back(mk(CMD_BYTE, '0, 8'h5A, 1'b1));
        drain();
        write_key('0, '0);
        pending.push_back(mk(CMD_KEY, '0, 8'h00, 1'b0));
        pending.push_back(mk(CMD_BYTE, '0, 8'h00, 1'b0));
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            write_key(rnd64(), rnd64());
            pending.push_back(mk(CMD_KEY, rnd64(), 8'($urandom), 1'($urandom)));
            for (int s = 0; s < 3; s++) random_session($urandom_range(5, 60));
            drain();
        end

        if (errors == 0) begin
            $display("rabbit_keystream_xor_top verification clean");
        end else begin
            $display("rabbit_keystream_xor_top verification failed");
        end
        $finish;
    end
endmodule
